// ===== design/assert_macros.svh =====
// Assertion helpers for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-gated
`define DSTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-gated
`define DSTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dsta_pkg.sv =====
package dsta_pkg;

    localparam int TS_W   = 64;
    localparam int RATE_W = 19;
    localparam int NS_W   = 30;
    localparam int BASE_W = 21;

    localparam logic [NS_W-1:0]   NS_PER_S        = NS_W'(1000000000);
    localparam logic [NS_W-1:0]   MIN_DURATION_NS = NS_W'(1000000);
    localparam logic [BASE_W-1:0] BASE_TOL_NS     = BASE_W'(500000);
    localparam logic [RATE_W-1:0] RATE_DEFAULT    = RATE_W'(48000);
    localparam logic [RATE_W-1:0] RATE_LOW        = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_HIGH       = RATE_W'(384000);
    localparam int                SOLO_MIN_DEPTH  = 3;

    localparam logic [1:0] FUNC_PUSH     = 2'd0;
    localparam logic [1:0] FUNC_POP      = 2'd1;
    localparam logic [1:0] FUNC_REANCHOR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_CHK,
        ST_PUSH_JUMP,
        ST_PUSH_APPLY,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POP_START,
        ST_POP_BASE,
        ST_POP_LOOP,
        ST_POP_RDB,
        ST_POP_CAPB,
        ST_POP_CMP,
        ST_FB_CAP,
        ST_REANCHOR,
        ST_RESULT
    } state_t;

endpackage

// ===== design/dsta_ram.sv =====
module dsta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dsta_div.sv =====
module dsta_div #(
    parameter int DW = 44
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [dsta_pkg::RATE_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [DW-1:0]               quotient
);
    import dsta_pkg::*;

    localparam int CW = $clog2(DW);

    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   trial;
    logic              ge;

    // restoring divide, one quotient bit per cycle shifted into the dividend
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DW-1]};
        ge        = (trial >= {1'b0, divisor});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? RATE_W'(trial - {1'b0, divisor}) : trial[RATE_W-1:0];
            dvd_next = {dvd_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== design/dual_stream_timestamp_aligner_top.sv =====
// Channel  | Handshake             | Beat contents
// ---------+-----------------------+---------------------------------------------
// input    | in_valid / in_ready   | func, slot, in_timestamp, frames
// result   | out_valid / out_ready | ok, present flags, entries, frames, ts, ...
// config   | cfg_valid / cfg_ready | cfg_data (sample rate)
//
// One item at a time. A push computes the duration only when it is needed
// (frames * 1e9 by a serial divide by the rate); a pop first divides for the
// one-sample period, then walks the head pairs: a pair with unequal frames
// drops one head, a pair with equal frames runs the duration divide and
// compares, and an empty side may send it to the fallback path.
// The result register lets the next item in while a result waits.
// Reset: queues empty, epoch 1, rate 48000. No clearing pass is needed.
module dual_stream_timestamp_aligner_top #(
    parameter int QUEUE_DEPTH = 4,
    parameter int MAX_FRAMES  = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic                        slot,
    input  logic [dsta_pkg::TS_W-1:0]   in_timestamp,
    input  logic [15:0]                 frames,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic                        a_present,
    output logic                        b_present,
    output logic [1:0]                  a_entry,
    output logic [1:0]                  b_entry,
    output logic [10:0]                 out_frames,
    output logic [dsta_pkg::TS_W-1:0]   out_timestamp,
    output logic                        solo_mix,
    output logic [2:0]                  depth_a,
    output logic [2:0]                  depth_b,
    output logic [31:0]                 epoch,
    output logic [31:0]                 discarded_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dsta_pkg::RATE_W-1:0] cfg_data
);
    import dsta_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int FR_W      = $clog2(MAX_FRAMES + 1);
    localparam int PROD_W    = FR_W + NS_W;
    localparam int ENT_W     = TS_W + FR_W;
    localparam int AW        = PTR_W + 1;
    localparam int RAM_DEPTH = 2 ** AW;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t state_reg, state_next, ret_reg, ret_next;

    logic              slot_reg, slot_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [15:0]       fr_reg, fr_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [PTR_W-1:0]  rp0_reg, rp0_next, rp1_reg, rp1_next;
    logic [CNT_W-1:0]  cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    logic [TS_W-1:0]   last0_reg, last0_next, last1_reg, last1_next;
    logic [31:0]       epoch_reg, epoch_next, discard_reg, discard_next;
    logic              jump_reg, jump_next;
    logic [FR_W-1:0]   fsel_reg, fsel_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [TS_W-1:0]   ta_reg, ta_next, tb_reg, tb_next;
    logic [FR_W-1:0]   fa_reg, fa_next;
    logic              fb_side_reg, fb_side_next;

    // pending result fields
    logic              r_ok_reg, r_ok_next, r_ap_reg, r_ap_next, r_bp_reg, r_bp_next;
    logic [PTR_W-1:0]  r_ae_reg, r_ae_next, r_be_reg, r_be_next;
    logic [FR_W-1:0]   r_fr_reg, r_fr_next;
    logic [TS_W-1:0]   r_ts_reg, r_ts_next;
    logic              r_sf_reg, r_sf_next;

    // output register
    logic              ov_reg, ov_next;
    logic              o_ok_reg, o_ok_next, o_ap_reg, o_ap_next, o_bp_reg, o_bp_next;
    logic [1:0]        o_ae_reg, o_ae_next, o_be_reg, o_be_next;
    logic [10:0]       o_fr_reg, o_fr_next;
    logic [TS_W-1:0]   o_ts_reg, o_ts_next;
    logic              o_sf_reg, o_sf_next;
    logic [2:0]        o_da_reg, o_da_next, o_db_reg, o_db_next;
    logic [31:0]       o_ep_reg, o_ep_next, o_dc_reg, o_dc_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic [TS_W-1:0]   rd_ts;
    logic [FR_W-1:0]   rd_fr;

    logic              div_start, div_busy, div_done;
    logic [PROD_W-1:0] div_q;

    assign rd_ts = ram_rdata[ENT_W-1:FR_W];
    assign rd_fr = ram_rdata[FR_W-1:0];

    dsta_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsta_div #(
        .DW (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (rate_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer: next state, queue updates, result assembly
    always_comb
    begin
        logic [TS_W-1:0]   prev;
        logic [PROD_W-1:0] dur;
        logic [PTR_W-1:0]  w_rp0, w_rp1, s_rp;
        logic [CNT_W-1:0]  w_c0, w_c1, s_c;
        logic [SUM_W-1:0]  sum;
        logic [PTR_W-1:0]  wptr;
        logic [BASE_W-1:0] b8;
        logic [TS_W-1:0]   diff, tol;

        state_next   = state_reg;
        ret_next     = ret_reg;
        slot_next    = slot_reg;
        ts_next      = ts_reg;
        fr_next      = fr_reg;
        rate_next    = rate_reg;
        rp0_next     = rp0_reg;
        rp1_next     = rp1_reg;
        cnt0_next    = cnt0_reg;
        cnt1_next    = cnt1_reg;
        last0_next   = last0_reg;
        last1_next   = last1_reg;
        epoch_next   = epoch_reg;
        discard_next = discard_reg;
        jump_next    = jump_reg;
        fsel_next    = fsel_reg;
        prod_next    = prod_reg;
        base_next    = base_reg;
        ta_next      = ta_reg;
        tb_next      = tb_reg;
        fa_next      = fa_reg;
        fb_side_next = fb_side_reg;
        r_ok_next    = r_ok_reg;
        r_ap_next    = r_ap_reg;
        r_bp_next    = r_bp_reg;
        r_ae_next    = r_ae_reg;
        r_be_next    = r_be_reg;
        r_fr_next    = r_fr_reg;
        r_ts_next    = r_ts_reg;
        r_sf_next    = r_sf_reg;
        ov_next      = ov_reg && !out_ready;
        o_ok_next    = o_ok_reg;
        o_ap_next    = o_ap_reg;
        o_bp_next    = o_bp_reg;
        o_ae_next    = o_ae_reg;
        o_be_next    = o_be_reg;
        o_fr_next    = o_fr_reg;
        o_ts_next    = o_ts_reg;
        o_sf_next    = o_sf_reg;
        o_da_next    = o_da_reg;
        o_db_next    = o_db_reg;
        o_ep_next    = o_ep_reg;
        o_dc_next    = o_dc_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = {ts_reg, fr_reg[FR_W-1:0]};
        ram_raddr    = '0;
        div_start    = 1'b0;
        in_ready     = 1'b0;
        cfg_ready    = 1'b0;

        prev  = slot_reg ? last1_reg : last0_reg;
        dur   = (div_q < PROD_W'(MIN_DURATION_NS)) ? PROD_W'(MIN_DURATION_NS) : div_q;
        w_rp0 = rp0_reg;
        w_rp1 = rp1_reg;
        w_c0  = cnt0_reg;
        w_c1  = cnt1_reg;
        s_rp  = '0;
        s_c   = '0;
        sum   = '0;
        wptr  = '0;
        b8    = {div_q[BASE_W-4:0], 3'b000};
        diff  = (tb_reg >= ta_reg) ? tb_reg - ta_reg : ta_reg - tb_reg;
        tol   = TS_W'(div_q) + TS_W'(base_reg);

        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    rate_next = (cfg_data >= RATE_LOW && cfg_data <= RATE_HIGH) ?
                                cfg_data : RATE_DEFAULT;
                    rp0_next     = '0;
                    rp1_next     = '0;
                    cnt0_next    = '0;
                    cnt1_next    = '0;
                    last0_next   = '0;
                    last1_next   = '0;
                    epoch_next   = 32'd1;
                    discard_next = '0;
                end
                else if (in_valid)
                begin
                    slot_next = slot;
                    ts_next   = in_timestamp;
                    fr_next   = frames;
                    r_ok_next = 1'b0;
                    r_ap_next = 1'b0;
                    r_bp_next = 1'b0;
                    r_ae_next = '0;
                    r_be_next = '0;
                    r_fr_next = '0;
                    r_ts_next = '0;
                    r_sf_next = 1'b0;
                    case (func)
                        FUNC_PUSH:     state_next = ST_PUSH_CHK;
                        FUNC_POP:      state_next = ST_POP_START;
                        FUNC_REANCHOR: state_next = ST_REANCHOR;
                        default:       state_next = ST_RESULT;
                    endcase
                end
            end

            // frame count check and the cheap discontinuity cases
            ST_PUSH_CHK:
            begin
                if (fr_reg == 16'd0 || fr_reg > 16'(MAX_FRAMES))
                begin
                    state_next = ST_RESULT;
                end
                else if (prev == '0)
                begin
                    jump_next  = 1'b0;
                    state_next = ST_PUSH_APPLY;
                end
                else if (ts_reg == '0 || ts_reg <= prev)
                begin
                    jump_next  = 1'b1;
                    state_next = ST_PUSH_APPLY;
                end
                else
                begin
                    fsel_next  = fr_reg[FR_W-1:0];
                    ret_next   = ST_PUSH_JUMP;
                    state_next = ST_MUL;
                end
            end

            ST_PUSH_JUMP:
            begin
                jump_next  = (ts_reg - prev) > TS_W'({dur, 4'b0000});
                state_next = ST_PUSH_APPLY;
            end

            // optional clear, overflow drop, append
            ST_PUSH_APPLY:
            begin
                if (jump_reg)
                begin
                    w_rp0      = '0;
                    w_rp1      = '0;
                    w_c0       = '0;
                    w_c1       = '0;
                    last0_next = '0;
                    last1_next = '0;
                    epoch_next = epoch_reg + 32'd1;
                end
                if (slot_reg)
                begin
                    last1_next = ts_reg;
                end
                else
                begin
                    last0_next = ts_reg;
                end
                s_rp = slot_reg ? w_rp1 : w_rp0;
                s_c  = slot_reg ? w_c1 : w_c0;
                if (s_c >= CNT_W'(QUEUE_DEPTH))
                begin
                    s_rp         = ptr_inc(s_rp);
                    s_c          = s_c - 1'b1;
                    discard_next = discard_reg + 32'd1;
                end
                sum  = SUM_W'(s_rp) + SUM_W'(s_c);
                wptr = (sum >= SUM_W'(QUEUE_DEPTH)) ?
                       PTR_W'(sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(sum);
                s_c  = s_c + 1'b1;
                if (slot_reg)
                begin
                    rp0_next  = w_rp0;
                    cnt0_next = w_c0;
                    rp1_next  = s_rp;
                    cnt1_next = s_c;
                end
                else
                begin
                    rp0_next  = s_rp;
                    cnt0_next = s_c;
                    rp1_next  = w_rp1;
                    cnt1_next = w_c1;
                end
                ram_we     = 1'b1;
                ram_waddr  = {slot_reg, wptr};
                r_ok_next  = 1'b1;
                r_ae_next  = wptr;
                state_next = ST_RESULT;
            end

            // shared duration path: frames * 1e9, then divide by the rate
            ST_MUL:
            begin
                prod_next  = PROD_W'(fsel_reg) * PROD_W'(NS_PER_S);
                state_next = ST_DIV_GO;
            end

            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ret_reg;
                end
            end

            // one-sample period for the base tolerance
            ST_POP_START:
            begin
                fsel_next  = FR_W'(1);
                ret_next   = ST_POP_BASE;
                state_next = ST_MUL;
            end

            ST_POP_BASE:
            begin
                base_next  = (b8 < BASE_TOL_NS) ? BASE_TOL_NS : b8;
                state_next = ST_POP_LOOP;
            end

            // head walk, or fallback when one side is empty and the other holds at least SOLO_MIN_DEPTH
            ST_POP_LOOP:
            begin
                if (cnt0_reg != '0 && cnt1_reg != '0)
                begin
                    ram_raddr  = {1'b0, rp0_reg};
                    state_next = ST_POP_RDB;
                end
                else if (cnt0_reg >= CNT_W'(SOLO_MIN_DEPTH) && cnt1_reg == '0)
                begin
                    ram_raddr    = {1'b0, rp0_reg};
                    fb_side_next = 1'b0;
                    state_next   = ST_FB_CAP;
                end
                else if (cnt1_reg >= CNT_W'(SOLO_MIN_DEPTH) && cnt0_reg == '0)
                begin
                    ram_raddr    = {1'b1, rp1_reg};
                    fb_side_next = 1'b1;
                    state_next   = ST_FB_CAP;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_POP_RDB:
            begin
                ram_raddr  = {1'b1, rp1_reg};
                ta_next    = rd_ts;
                fa_next    = rd_fr;
                state_next = ST_POP_CAPB;
            end

            ST_POP_CAPB:
            begin
                tb_next = rd_ts;
                if (fa_reg == rd_fr)
                begin
                    fsel_next  = fa_reg;
                    ret_next   = ST_POP_CMP;
                    state_next = ST_MUL;
                end
                else
                begin
                    if (ta_reg <= rd_ts)
                    begin
                        rp0_next  = ptr_inc(rp0_reg);
                        cnt0_next = cnt0_reg - 1'b1;
                    end
                    else
                    begin
                        rp1_next  = ptr_inc(rp1_reg);
                        cnt1_next = cnt1_reg - 1'b1;
                    end
                    discard_next = discard_reg + 32'd1;
                    state_next   = ST_POP_LOOP;
                end
            end

            ST_POP_CMP:
            begin
                if (diff <= tol)
                begin
                    r_ok_next  = 1'b1;
                    r_ap_next  = 1'b1;
                    r_bp_next  = 1'b1;
                    r_ae_next  = rp0_reg;
                    r_be_next  = rp1_reg;
                    r_fr_next  = fa_reg;
                    r_ts_next  = (ta_reg < tb_reg) ? ta_reg : tb_reg;
                    rp0_next   = ptr_inc(rp0_reg);
                    cnt0_next  = cnt0_reg - 1'b1;
                    rp1_next   = ptr_inc(rp1_reg);
                    cnt1_next  = cnt1_reg - 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (ta_reg <= tb_reg)
                    begin
                        rp0_next  = ptr_inc(rp0_reg);
                        cnt0_next = cnt0_reg - 1'b1;
                    end
                    else
                    begin
                        rp1_next  = ptr_inc(rp1_reg);
                        cnt1_next = cnt1_reg - 1'b1;
                    end
                    discard_next = discard_reg + 32'd1;
                    state_next   = ST_POP_LOOP;
                end
            end

            ST_FB_CAP:
            begin
                r_ok_next = 1'b1;
                r_fr_next = rd_fr;
                r_ts_next = rd_ts;
                r_sf_next = 1'b1;
                if (fb_side_reg)
                begin
                    r_bp_next = 1'b1;
                    r_be_next = rp1_reg;
                    rp1_next  = ptr_inc(rp1_reg);
                    cnt1_next = cnt1_reg - 1'b1;
                end
                else
                begin
                    r_ap_next = 1'b1;
                    r_ae_next = rp0_reg;
                    rp0_next  = ptr_inc(rp0_reg);
                    cnt0_next = cnt0_reg - 1'b1;
                end
                state_next = ST_RESULT;
            end

            ST_REANCHOR:
            begin
                rp0_next   = '0;
                rp1_next   = '0;
                cnt0_next  = '0;
                cnt1_next  = '0;
                last0_next = '0;
                last1_next = '0;
                epoch_next = epoch_reg + 32'd1;
                state_next = ST_RESULT;
            end

            // hand the beat to the output register once it is free
            ST_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    o_ok_next  = r_ok_reg;
                    o_ap_next  = r_ap_reg;
                    o_bp_next  = r_bp_reg;
                    o_ae_next  = 2'(r_ae_reg);
                    o_be_next  = 2'(r_be_reg);
                    o_fr_next  = 11'(r_fr_reg);
                    o_ts_next  = r_ts_reg;
                    o_sf_next  = r_sf_reg;
                    o_da_next  = 3'(cnt0_reg);
                    o_db_next  = 3'(cnt1_reg);
                    o_ep_next  = epoch_reg;
                    o_dc_next  = discard_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            rate_reg    <= RATE_DEFAULT;
            rp0_reg     <= '0;
            rp1_reg     <= '0;
            cnt0_reg    <= '0;
            cnt1_reg    <= '0;
            last0_reg   <= '0;
            last1_reg   <= '0;
            epoch_reg   <= 32'd1;
            discard_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            rate_reg    <= rate_next;
            rp0_reg     <= rp0_next;
            rp1_reg     <= rp1_next;
            cnt0_reg    <= cnt0_next;
            cnt1_reg    <= cnt1_next;
            last0_reg   <= last0_next;
            last1_reg   <= last1_next;
            epoch_reg   <= epoch_next;
            discard_reg <= discard_next;
            ov_reg      <= ov_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        ts_reg      <= ts_next;
        fr_reg      <= fr_next;
        jump_reg    <= jump_next;
        fsel_reg    <= fsel_next;
        prod_reg    <= prod_next;
        base_reg    <= base_next;
        ta_reg      <= ta_next;
        tb_reg      <= tb_next;
        fa_reg      <= fa_next;
        fb_side_reg <= fb_side_next;
        r_ok_reg    <= r_ok_next;
        r_ap_reg    <= r_ap_next;
        r_bp_reg    <= r_bp_next;
        r_ae_reg    <= r_ae_next;
        r_be_reg    <= r_be_next;
        r_fr_reg    <= r_fr_next;
        r_ts_reg    <= r_ts_next;
        r_sf_reg    <= r_sf_next;
        o_ok_reg    <= o_ok_next;
        o_ap_reg    <= o_ap_next;
        o_bp_reg    <= o_bp_next;
        o_ae_reg    <= o_ae_next;
        o_be_reg    <= o_be_next;
        o_fr_reg    <= o_fr_next;
        o_ts_reg    <= o_ts_next;
        o_sf_reg    <= o_sf_next;
        o_da_reg    <= o_da_next;
        o_db_reg    <= o_db_next;
        o_ep_reg    <= o_ep_next;
        o_dc_reg    <= o_dc_next;
    end

    assign out_valid        = ov_reg;
    assign ok               = o_ok_reg;
    assign a_present        = o_ap_reg;
    assign b_present        = o_bp_reg;
    assign a_entry          = o_ae_reg;
    assign b_entry          = o_be_reg;
    assign out_frames       = o_fr_reg;
    assign out_timestamp    = o_ts_reg;
    assign solo_mix         = o_sf_reg;
    assign depth_a          = o_da_reg;
    assign depth_b          = o_db_reg;
    assign epoch            = o_ep_reg;
    assign discarded_count  = o_dc_reg;

    `DSTA_ASSERT_NOW(a_cnt_bound, 1'b1,
        (cnt0_reg <= CNT_W'(QUEUE_DEPTH)) && (cnt1_reg <= CNT_W'(QUEUE_DEPTH)),
        "queue count above depth")
    `DSTA_ASSERT_NEXT(a_cfg_reset_counts, cfg_valid && cfg_ready,
        (epoch_reg == 32'd1) && (discard_reg == 32'd0) && (cnt0_reg == '0),
        "config write did not reset counters")
    `DSTA_ASSERT_NOW(a_div_idle_start, div_start, !div_busy,
        "divider started while busy")

endmodule
